// ----- sv/top_k_count_selector_unit_assert.svh -----
// Assertion macros for the top-k count selector checker.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef TOP_K_COUNT_SELECTOR_UNIT_ASSERT_SVH
`define TOP_K_COUNT_SELECTOR_UNIT_ASSERT_SVH

// same-cycle implication
`define TKCS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("top_k_count_selector_unit: assertion failed");

// next-cycle implication
`define TKCS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("top_k_count_selector_unit: assertion failed");

`endif

// ----- sv/tkcs_pkg.sv -----
// Shared types and defaults for the top-k count selector.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tkcs_pkg;

	localparam int MAX_SLOTS_DEF   = 8;
	localparam int MAX_BUCKETS_DEF = 65536;

	localparam int IDX_W   = 16;
	localparam int COUNT_W = 32;
	localparam int RANK_PW = 6;

	// one slot entry
	typedef struct packed {
		logic [IDX_W-1:0]   idx;
		logic [COUNT_W-1:0] count;
	} slot_t;

	// controls broadcast to every cell
	typedef struct packed {
		logic insert;   // accepted word is taken into the list
		logic fill;     // first word of a set: all cells load it
		logic drain;    // output word taken: list moves up one
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/tkcs_cell.sv -----
// One slot of the sorted insertion chain.
// Depends on tkcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tkcs_cell import tkcs_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_ctrl_t ctrl,
	input  wire slot_t      new_slot,    // incoming word
	input  wire slot_t      above_slot,  // neighbor one rank higher
	input  wire logic       above_gt,    // new count beats the neighbor above
	input  wire slot_t      below_slot,  // neighbor one rank lower
	output slot_t           slot,
	output logic            gt
);

	slot_t slot_q;

	// strict compare keeps earlier entries ahead on ties
	assign gt   = new_slot.count > slot_q.count;
	assign slot = slot_q;

	// insert, shift down, or shift up on drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (ctrl.drain) begin
			slot_q <= below_slot;
		end else if (ctrl.insert) begin
			if (ctrl.fill) begin
				slot_q <= new_slot;
			end else if (above_gt) begin
				slot_q <= above_slot;
			end else if (gt) begin
				slot_q <= new_slot;
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/top_k_count_selector_unit.sv -----
// Top-k count selector: keeps the MAX_SLOTS largest bucket counts of a set.
// Depends on tkcs_pkg and tkcs_cell.
`timescale 1ns / 1ps
`default_nettype none

// Bucket counts stream in, one word per cycle, each taking its index from an
// internal position counter; a row of MAX_SLOTS cells keeps them sorted in
// descending order (ties keep the earlier bucket ahead), and every cell
// compares the incoming count with its own in the same cycle, so a word is
// taken every clock while a set is filling. Words beyond MAX_BUCKETS in a
// set are dropped. The word flagged last_bucket ends the set: its count is
// inserted, then the row shifts toward rank 0 and delivers MAX_SLOTS result
// words, one per accepted output cycle, with last_rank on the final one.
// in_ready is low while those result words are delivered, so the next set
// cannot start until the final result word is taken.
module top_k_count_selector_unit import tkcs_pkg::*; #(
	parameter int MAX_SLOTS   = MAX_SLOTS_DEF,
	parameter int MAX_BUCKETS = MAX_BUCKETS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [COUNT_W-1:0] bucket_count,
	input  wire logic               last_bucket,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [RANK_PW-1:0]      rank,
	output logic [IDX_W-1:0]        bucket_index,
	output logic [COUNT_W-1:0]      count_value,
	output logic                    last_rank
);

	localparam int POS_W  = $clog2(MAX_BUCKETS + 1);
	localparam int RANK_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

	logic [POS_W-1:0]  pos_q;
	logic [RANK_W-1:0] rank_q;
	logic              drain_q;

	logic       in_acc, out_acc, take, rank_end;
	slot_t      new_slot;
	cell_ctrl_t ctrl;
	slot_t      slots [MAX_SLOTS];
	logic       gts   [MAX_SLOTS];

	// handshake
	assign in_ready  = !drain_q;
	assign in_acc    = in_valid && in_ready;
	assign out_valid = drain_q;
	assign out_acc   = out_valid && out_ready;
	assign take      = in_acc && (pos_q != POS_W'(MAX_BUCKETS));
	assign rank_end  = rank_q == RANK_W'(MAX_SLOTS - 1);

	// incoming word and cell controls
	assign new_slot.idx   = IDX_W'(pos_q);
	assign new_slot.count = bucket_count;
	assign ctrl.insert    = take;
	assign ctrl.fill      = pos_q == '0;
	assign ctrl.drain     = out_acc;

	// position counter, set end and output ranking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			rank_q  <= '0;
			drain_q <= 1'b0;
		end else begin
			if (in_acc) begin
				if (last_bucket) begin
					pos_q   <= '0;
					rank_q  <= '0;
					drain_q <= 1'b1;
				end else if (take) begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
			if (out_acc) begin
				rank_q <= rank_q + RANK_W'(1);
				if (rank_end) begin
					drain_q <= 1'b0;
				end
			end
		end
	end

	// row of cells
	for (genvar j = 0; j < MAX_SLOTS; j++) begin : g_cell
		slot_t above_s, below_s;
		logic  above_g;

		if (j == 0) begin : g_head
			assign above_s = '0;
			assign above_g = 1'b0;
		end else begin : g_mid
			assign above_s = slots[j-1];
			assign above_g = gts[j-1];
		end

		if (j == MAX_SLOTS - 1) begin : g_tail
			assign below_s = slots[j];
		end else begin : g_body
			assign below_s = slots[j+1];
		end

		tkcs_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_slot   (new_slot),
			.above_slot (above_s),
			.above_gt   (above_g),
			.below_slot (below_s),
			.slot       (slots[j]),
			.gt         (gts[j])
		);
	end

	// rank 0 cell drives the output word
	assign rank         = RANK_PW'(rank_q);
	assign bucket_index = slots[0].idx;
	assign count_value  = slots[0].count;
	assign last_rank    = rank_end;

endmodule

`default_nettype wire

// ----- sv/tkcs_checker.sv -----
// Port-level checks for the top-k count selector, bound to the top level.
// Depends on tkcs_pkg and top_k_count_selector_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "top_k_count_selector_unit_assert.svh"

module tkcs_checker import tkcs_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               last_bucket,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [RANK_PW-1:0] rank,
	input wire logic [IDX_W-1:0]   bucket_index,
	input wire logic [COUNT_W-1:0] count_value,
	input wire logic               last_rank
);

	// a stalled result word holds
	`TKCS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(rank) && $stable(bucket_index) && $stable(count_value))

	// no input taken while results are delivered
	`TKCS_ASSERT_NOW(a_no_overlap, out_valid, !in_ready)

	// a last word starts the result burst at rank 0
	`TKCS_ASSERT_NEXT(a_burst_start, in_valid && in_ready && last_bucket, out_valid && rank == '0)

	// ranks advance by one inside a burst
	`TKCS_ASSERT_NEXT(a_rank_step, out_valid && out_ready && !last_rank, out_valid && rank == $past(rank) + 1'b1)

	// burst ends after the last rank
	`TKCS_ASSERT_NEXT(a_burst_end, out_valid && out_ready && last_rank, !out_valid)

endmodule

bind top_k_count_selector_unit tkcs_checker u_tkcs_checker (.*);

`default_nettype wire
